// ===== rtl/btni_pkg.sv =====
// ----------------------------------------------------------------------------
// btni_pkg
// Shared sizes, status codes and the result record for the index-node core.
// ----------------------------------------------------------------------------
package btni_pkg;

  // node capacity in entries
  localparam int CAPACITY = 32;
  // entry count width (holds 0..CAPACITY)
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // entry address width
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int KEY_W    = 32;
  localparam int CHILD_W  = 32;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // one result transaction
  typedef struct packed {
    status_t                    status;
    logic                       now_full;
    logic                       key_valid;
    logic signed [KEY_W-1:0]    sibling_key;
    logic        [CHILD_W-1:0]  sibling_child;
    logic signed [KEY_W-1:0]    promoted_key;
    logic        [CNT_W-1:0]    node_count;
    logic                       sibling_is_index;
    logic                       last;
  } result_t;

endpackage

// ===== rtl/btni_ram.sv =====
// ----------------------------------------------------------------------------
// btni_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module btni_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/btree_node_insert_split_core.sv =====
// ----------------------------------------------------------------------------
// btree_node_insert_split_core
// One B+ tree internal node held in key and child RAMs: sorted insert and split.
// ----------------------------------------------------------------------------
// Insert: the key RAM is scanned from the top entry down, one entry per cycle,
//   shifting entries up until the lower-bound slot is found, and the result
//   is registered. Full-node reject and empty-node insert skip the scan.
// Split: promoted key first, then one result per cycle from the RAM read ports
//   unless the output stalls (count - count/2 results). One item is worked at a time.
// Reset clears the state, the entry count, the configuration register and out_valid; RAM contents are not cleared.
module btree_node_insert_split_core
  import btni_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic signed [KEY_W-1:0]   new_key,
  input  logic        [CHILD_W-1:0] new_child,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic        [1:0]         status,
  output logic                      now_full,
  output logic                      key_valid,
  output logic signed [KEY_W-1:0]   sibling_key,
  output logic        [CHILD_W-1:0] sibling_child,
  output logic signed [KEY_W-1:0]   promoted_key,
  output logic        [CNT_W-1:0]   node_count,
  output logic                      sibling_is_index,
  output logic                      last,
  // configuration
  input  logic                      cfg_wen,
  input  logic                      cfg_wdata
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_START = 7'b0000010,
    ST_INS   = 7'b0000100,
    ST_PUT   = 7'b0001000,
    ST_PROM  = 7'b0010000,
    ST_SPLIT = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t                     state, state_next;
  logic        [CNT_W-1:0]    count, count_next;
  logic        [CNT_W-1:0]    idx, idx_next;
  logic signed [KEY_W-1:0]    prom, prom_next;
  result_t                    res, res_next;
  logic                       children_are_index;
  logic                       op_q;
  logic signed [KEY_W-1:0]    key_q;
  logic        [CHILD_W-1:0]  child_q;

  // RAM ports
  logic                       ram_we;
  logic        [ADDR_W-1:0]   ram_waddr;
  logic        [KEY_W-1:0]    ram_wkey;
  logic        [CHILD_W-1:0]  ram_wchild;
  logic        [ADDR_W-1:0]   key_raddr, child_raddr;
  logic        [KEY_W-1:0]    key_rdata;
  logic        [CHILD_W-1:0]  child_rdata;

  // output register
  logic                       out_free;
  logic                       out_ld;
  result_t                    out_res;
  result_t                    out_q;

  logic        [CNT_W-1:0]    mid;
  logic                       is_last;
  logic                       shift_up;
  logic        [CNT_W-1:0]    count_inc;

  // key i lives at key RAM address i; its right child at child RAM address i
  btni_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wkey),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  btni_ram #(.WIDTH(CHILD_W), .DEPTH(CAPACITY)) u_child_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wchild),
    .raddr (child_raddr),
    .rdata (child_rdata)
  );

  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign mid       = count >> 1;
  assign is_last   = (idx == count - CNT_W'(1));
  assign shift_up  = ($signed(key_rdata) >= key_q);
  assign count_inc = count + CNT_W'(1);

  // sequence the RAM accesses and build results
  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    prom_next   = prom;
    res_next    = res;
    ram_we      = 1'b0;
    ram_waddr   = idx[ADDR_W-1:0];
    ram_wkey    = key_q;
    ram_wchild  = child_q;
    key_raddr   = '0;
    child_raddr = '0;
    out_ld      = 1'b0;
    out_res     = res;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_START;
        end
      end

      ST_START: begin
        res_next      = '0;
        res_next.last = 1'b1;
        if (!op_q) begin
          if (count == CNT_W'(CAPACITY)) begin
            res_next.status     = STATUS_FULL;
            res_next.now_full   = 1'b1;
            res_next.node_count = count;
            state_next          = ST_EMIT;
          end else if (count == '0) begin
            // empty node: place the entry directly
            ram_we              = 1'b1;
            ram_waddr           = '0;
            count_next          = count_inc;
            res_next.status     = STATUS_OK;
            res_next.now_full   = (count_inc == CNT_W'(CAPACITY));
            res_next.node_count = count_inc;
            state_next          = ST_EMIT;
          end else begin
            key_raddr   = ADDR_W'(count - CNT_W'(1));
            child_raddr = ADDR_W'(count - CNT_W'(1));
            idx_next    = count;
            state_next  = ST_INS;
          end
        end else begin
          if (count == '0) begin
            res_next.status = STATUS_EMPTY;
            state_next      = ST_EMIT;
          end else begin
            key_raddr  = ADDR_W'(mid);
            state_next = ST_PROM;
          end
        end
      end

      ST_INS: begin
        ram_we = 1'b1;
        if (shift_up) begin
          // move entry idx-1 up to idx
          ram_wkey   = key_rdata;
          ram_wchild = child_rdata;
          idx_next   = idx - CNT_W'(1);
          if (idx == CNT_W'(1)) begin
            state_next = ST_PUT;
          end else begin
            key_raddr   = ADDR_W'(idx - CNT_W'(2));
            child_raddr = ADDR_W'(idx - CNT_W'(2));
          end
        end else begin
          count_next          = count_inc;
          res_next            = '0;
          res_next.status     = STATUS_OK;
          res_next.now_full   = (count_inc == CNT_W'(CAPACITY));
          res_next.node_count = count_inc;
          res_next.last       = 1'b1;
          state_next          = ST_EMIT;
        end
      end

      ST_PUT: begin
        ram_we              = 1'b1;
        count_next          = count_inc;
        res_next            = '0;
        res_next.status     = STATUS_OK;
        res_next.now_full   = (count_inc == CNT_W'(CAPACITY));
        res_next.node_count = count_inc;
        res_next.last       = 1'b1;
        state_next          = ST_EMIT;
      end

      ST_PROM: begin
        prom_next   = $signed(key_rdata);
        key_raddr   = ADDR_W'(mid + CNT_W'(1));
        child_raddr = ADDR_W'(mid);
        idx_next    = mid;
        state_next  = ST_SPLIT;
      end

      ST_SPLIT: begin
        // hold the read addresses while the output is stalled
        key_raddr   = ADDR_W'(idx + CNT_W'(1));
        child_raddr = ADDR_W'(idx);
        if (out_free) begin
          out_ld                   = 1'b1;
          out_res                  = '0;
          out_res.status           = STATUS_OK;
          out_res.key_valid        = !is_last;
          out_res.sibling_key      = is_last ? '0 : $signed(key_rdata);
          out_res.sibling_child    = child_rdata;
          out_res.promoted_key     = prom;
          out_res.node_count       = mid;
          out_res.sibling_is_index = children_are_index;
          out_res.last             = is_last;
          if (is_last) begin
            count_next = mid;
            state_next = ST_IDLE;
          end else begin
            idx_next    = idx + CNT_W'(1);
            key_raddr   = ADDR_W'(idx + CNT_W'(2));
            child_raddr = ADDR_W'(idx + CNT_W'(1));
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_ld     = 1'b1;
          out_res    = res;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      count              <= '0;
      children_are_index <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_wen) begin
        children_are_index <= cfg_wdata;
      end
      if (out_ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx  <= idx_next;
    prom <= prom_next;
    res  <= res_next;
    if (state == ST_IDLE && in_valid) begin
      op_q    <= op;
      key_q   <= new_key;
      child_q <= new_child;
    end
    if (out_ld) begin
      out_q <= out_res;
    end
  end

  assign status           = out_q.status;
  assign now_full         = out_q.now_full;
  assign key_valid        = out_q.key_valid;
  assign sibling_key      = out_q.sibling_key;
  assign sibling_child    = out_q.sibling_child;
  assign promoted_key     = out_q.promoted_key;
  assign node_count       = out_q.node_count;
  assign sibling_is_index = out_q.sibling_is_index;
  assign last             = out_q.last;

  // entry count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // RAM writes only during insert
  a_write_insert: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_START || state == ST_INS || state == ST_PUT))
    else $error("RAM write outside insert");

  // the last split result returns the core to idle with the lower half kept
  a_split_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SPLIT && out_ld && is_last) |=> (state == ST_IDLE && count == $past(mid)))
    else $error("split did not finish cleanly");

  // a result is never loaded over one that is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !out_ld)
    else $error("output overwritten while stalled");

endmodule

// ===== bench/btree_node_insert_split_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// btree_node_insert_split_core_test
// Self-checking bench for the index-node insert/split core. A directed table
// covers the extremes, ties, empty and one-entry splits. It is followed by
// random fill-then-split sequences under random handshake gaps and a long
// result stall. Every result transaction is compared field by field against
// a node predictor kept inside the bench.
// ----------------------------------------------------------------------------
module btree_node_insert_split_core_test;
  import btni_pkg::*;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SPLIT  = 1'b1;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam int RANDOM_ITEMS = 370;
  localparam int PHASE_ITEMS  = 46;
  localparam int LONG_HOLD    = 200;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      op;
  logic signed [KEY_W-1:0]   new_key;
  logic        [CHILD_W-1:0] new_child;
  logic                      out_valid;
  logic                      out_stall;
  logic        [1:0]         status;
  logic                      now_full;
  logic                      key_valid;
  logic signed [KEY_W-1:0]   sibling_key;
  logic        [CHILD_W-1:0] sibling_child;
  logic signed [KEY_W-1:0]   promoted_key;
  logic        [CNT_W-1:0]   node_count;
  logic                      sibling_is_index;
  logic                      last;
  logic                      cfg_wen;
  logic                      cfg_wdata;

  btree_node_insert_split_core u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .new_key          (new_key),
    .new_child        (new_child),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .now_full         (now_full),
    .key_valid        (key_valid),
    .sibling_key      (sibling_key),
    .sibling_child    (sibling_child),
    .promoted_key     (promoted_key),
    .node_count       (node_count),
    .sibling_is_index (sibling_is_index),
    .last             (last),
    .cfg_wen          (cfg_wen),
    .cfg_wdata        (cfg_wdata)
  );

  // node predictor state
  logic signed [KEY_W-1:0]   node_keys [CAPACITY];
  // slot i+1 holds the child right of key i
  logic        [CHILD_W-1:0] node_kids [CAPACITY+1];
  int                        node_size;
  logic                      index_cfg;

  result_t results_due [$];
  int      mismatch_count;
  int      send_idle_max;
  int      recv_idle_max;
  bit      long_hold_due;

  // directed stimulus; want_* is typed in only where typed is set
  typedef struct {
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic [CHILD_W-1:0]      child;
    bit                      typed;
    status_t                 want_status;
    logic [CNT_W-1:0]        want_count;
    logic                    want_full;
  } plan_row_t;

  plan_row_t warmup_plan [17] = '{
    '{OP_SPLIT,  '0,       32'h0000_0000, 1'b1, STATUS_EMPTY, 6'd0, 1'b0},
    '{OP_INSERT, KEY_MAX,  32'hFFFF_FFFF, 1'b1, STATUS_OK,    6'd1, 1'b0},
    '{OP_INSERT, KEY_MIN,  32'h0000_0000, 1'b1, STATUS_OK,    6'd2, 1'b0},
    '{OP_INSERT, '0,       32'hA5A5_A5A5, 1'b1, STATUS_OK,    6'd3, 1'b0},
    // equal key lands ahead of the existing one
    '{OP_INSERT, '0,       32'h5A5A_5A5A, 1'b1, STATUS_OK,    6'd4, 1'b0},
    '{OP_INSERT, '1,       32'h1234_5678, 1'b1, STATUS_OK,    6'd5, 1'b0},
    '{OP_INSERT, 32'sd1,   32'h8000_0001, 1'b1, STATUS_OK,    6'd6, 1'b0},
    '{OP_SPLIT,  '0,       32'h0000_0000, 1'b0, STATUS_OK,    6'd0, 1'b0},
    '{OP_INSERT, KEY_MIN,  32'h0000_0001, 1'b1, STATUS_OK,    6'd4, 1'b0},
    '{OP_INSERT, KEY_MAX,  32'hFFFF_FFFE, 1'b1, STATUS_OK,    6'd5, 1'b0},
    // split ignores key and child
    '{OP_SPLIT,  32'sh7777, 32'h0000_9999, 1'b0, STATUS_OK,   6'd0, 1'b0},
    '{OP_SPLIT,  '0,       32'h0000_0000, 1'b0, STATUS_OK,    6'd0, 1'b0},
    // one-entry node: final child only, node left empty
    '{OP_SPLIT,  '0,       32'h0000_0000, 1'b0, STATUS_OK,    6'd0, 1'b0},
    '{OP_SPLIT,  KEY_MAX,  32'hFFFF_FFFF, 1'b1, STATUS_EMPTY, 6'd0, 1'b0},
    '{OP_INSERT, -32'sd2,  32'hDEAD_BEEF, 1'b1, STATUS_OK,    6'd1, 1'b0},
    '{OP_INSERT, -32'sd2,  32'h0BAD_F00D, 1'b1, STATUS_OK,    6'd2, 1'b0},
    '{OP_SPLIT,  '0,       32'h0000_0000, 1'b0, STATUS_OK,    6'd0, 1'b0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(64'd10_000_000);
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // apply one transaction to the node predictor and queue its results
  task automatic node_apply(input logic o, input logic signed [KEY_W-1:0] k,
                            input logic [CHILD_W-1:0] c);
    result_t r;
    int      pos;
    int      mid;
    logic signed [KEY_W-1:0] promo;
    r = '0;
    r.node_count = node_size[CNT_W-1:0];
    r.last = 1'b1;
    if (o == OP_INSERT) begin
      if (node_size >= CAPACITY) begin
        // full node: reject, nothing moves
        r.status = STATUS_FULL;
        r.now_full = 1'b1;
        results_due.push_back(r);
        return;
      end
      pos = 0;
      while (pos < node_size && node_keys[pos] < k) pos++;
      for (int i = node_size; i > pos; i--) begin
        node_keys[i] = node_keys[i-1];
        node_kids[i+1] = node_kids[i];
      end
      node_keys[pos] = k;
      node_kids[pos+1] = c;
      node_size++;
      r.node_count = node_size[CNT_W-1:0];
      r.now_full = (node_size == CAPACITY);
      results_due.push_back(r);
    end else begin
      if (node_size == 0) begin
        r.status = STATUS_EMPTY;
        results_due.push_back(r);
        return;
      end
      mid = node_size / 2;
      promo = node_keys[mid];
      r.promoted_key = promo;
      r.node_count = mid[CNT_W-1:0];
      r.sibling_is_index = index_cfg;
      // stream upper keys with their children, then the final child
      r.key_valid = 1'b1;
      r.last = 1'b0;
      for (int i = mid + 1; i < node_size; i++) begin
        r.sibling_key = node_keys[i];
        r.sibling_child = node_kids[i];
        results_due.push_back(r);
      end
      r.key_valid = 1'b0;
      r.sibling_key = '0;
      r.sibling_child = node_kids[node_size];
      r.last = 1'b1;
      results_due.push_back(r);
      node_size = mid;
    end
  endtask

  // offer one transaction after a random gap, hold it until accepted
  task automatic offer_item(input logic o, input logic signed [KEY_W-1:0] k,
                            input logic [CHILD_W-1:0] c);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    op        <= o;
    new_key   <= k;
    new_child <= c;
    do @(posedge clk); while (in_stall);
    node_apply(o, k, c);
  endtask

  // drop valid and wait until every expected result has come back
  task automatic wait_node_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_index_cfg(input logic v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    index_cfg = v;
  endtask

  // keys biased toward ties and extremes
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 6)) - 3;
      1: begin
        case ($urandom_range(0, 3))
          0:       return KEY_MIN;
          1:       return KEY_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic check_result();
    result_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result with nothing expected");
      return;
    end
    want = results_due.pop_front();
    check_field("status",           status,           want.status);
    check_field("now_full",         now_full,         want.now_full);
    check_field("key_valid",        key_valid,        want.key_valid);
    check_field("sibling_key",      sibling_key,      want.sibling_key);
    check_field("sibling_child",    sibling_child,    want.sibling_child);
    check_field("promoted_key",     promoted_key,     want.promoted_key);
    check_field("node_count",       node_count,       want.node_count);
    check_field("sibling_is_index", sibling_is_index, want.sibling_is_index);
    check_field("last",             last,             want.last);
  endtask

  // result side: random stall per transaction, one long hold on request
  initial begin : result_side
    int stall_len;
    out_stall = 1'b0;
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        stall_len = LONG_HOLD;
      end else begin
        stall_len = $urandom_range(0, recv_idle_max);
      end
      repeat (stall_len) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_result();
    end
  end

  // stimulus
  initial begin : item_side
    result_t typed_r;
    int      random_items;
    int      next_phase_at;
    int      phase;
    int      n_ins;
    int      n_split;
    rst           = 1'b1;
    in_valid      = 1'b0;
    op            = OP_INSERT;
    new_key       = '0;
    new_child     = '0;
    cfg_wen       = 1'b0;
    cfg_wdata     = 1'b0;
    node_size     = 0;
    index_cfg     = 1'b0;
    mismatch_count = 0;
    send_idle_max = 10;
    recv_idle_max = 10;
    long_hold_due = 1'b0;
    random_items  = 0;
    next_phase_at = 0;
    phase         = 0;

    // hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (warmup_plan[i]) begin
      offer_item(warmup_plan[i].op, warmup_plan[i].key, warmup_plan[i].child);
      if (warmup_plan[i].typed) begin
        typed_r = '0;
        typed_r.status     = warmup_plan[i].want_status;
        typed_r.now_full   = warmup_plan[i].want_full;
        typed_r.node_count = warmup_plan[i].want_count;
        typed_r.last       = 1'b1;
        void'(results_due.pop_back());
        results_due.push_back(typed_r);
      end
    end

    // random fill-then-split sequences with some noise
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= next_phase_at) begin
        wait_node_idle();
        phase++;
        write_index_cfg(phase[0]);
        send_idle_max = (phase % 3 == 0) ? 0 : 10;
        recv_idle_max = (phase % 4 == 1) ? 0 : 10;
        if (phase == 2) begin
          // back up the block behind a stalled result channel
          send_idle_max = 0;
          long_hold_due = 1'b1;
        end
        next_phase_at += PHASE_ITEMS;
      end
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 3) == 0)
          n_ins = CAPACITY - node_size + $urandom_range(0, 2);
        else
          n_ins = $urandom_range(1, 8);
        repeat (n_ins) begin
          offer_item(OP_INSERT, pick_key(), $urandom());
          random_items++;
        end
        n_split = $urandom_range(1, 2);
        repeat (n_split) begin
          offer_item(OP_SPLIT, $urandom(), $urandom());
          random_items++;
        end
      end else begin
        offer_item($urandom_range(0, 1), pick_key(), $urandom());
        random_items++;
      end
    end

    // drain, then allow for the longest insert latency
    @(negedge clk);
    in_valid <= 1'b0;
    for (int w = 0; w < 100000 && results_due.size() != 0; w++) @(posedge clk);
    repeat (60) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
